// ===== design/vhlt_pkg.sv =====
`default_nettype none

package vhlt_pkg;

    localparam int CHAR_W   = 8;
    localparam int ROLE_W   = 3;
    localparam int PAIR_W   = 8;
    localparam int TYPE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int KLEN_W   = 3;
    localparam int NCAND    = 3;

    // Byte codes the parser looks for
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;

    // Byte roles
    localparam logic [ROLE_W-1:0] ROLE_PREFIX = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_HKEY   = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_DELIM  = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_PLAIN  = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_PKEY   = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_PVAL   = 3'd5;
    localparam logic [ROLE_W-1:0] ROLE_CLOSE  = 3'd6;

    // Line types
    localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_FORMAT  = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_FILTER  = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_INFO    = 2'd3;

    // Line status
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PREFIX = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_EQUALS  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_CLOSE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OPEN_PKEY  = 3'd4;

    // Key length of each candidate: FORMAT, FILTER, INFO
    localparam logic [KLEN_W-1:0] CAND_LEN [NCAND] = '{3'd6, 3'd6, 3'd4};

    typedef struct packed {
        logic [CHAR_W-1:0]   char_out;
        logic [ROLE_W-1:0]   role;
        logic [PAIR_W-1:0]   pair_number;
        logic [TYPE_W-1:0]   line_type;
        logic                indexable;
        logic [STATUS_W-1:0] status;
        logic                last_out;
    } t_result;

    // Upper-case letter of candidate key idx at position pos
    function automatic logic [CHAR_W-1:0] cand_char(input logic [1:0] idx,
                                                    input logic [KLEN_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        ch = 8'h00;
        case (idx)
            2'd0: begin
                case (pos)
                    3'd0: ch = 8'h46; // F
                    3'd1: ch = 8'h4F; // O
                    3'd2: ch = 8'h52; // R
                    3'd3: ch = 8'h4D; // M
                    3'd4: ch = 8'h41; // A
                    3'd5: ch = 8'h54; // T
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                case (pos)
                    3'd0: ch = 8'h46; // F
                    3'd1: ch = 8'h49; // I
                    3'd2: ch = 8'h4C; // L
                    3'd3: ch = 8'h54; // T
                    3'd4: ch = 8'h45; // E
                    3'd5: ch = 8'h52; // R
                    default: ch = 8'h00;
                endcase
            end
            2'd2: begin
                case (pos)
                    3'd0: ch = 8'h49; // I
                    3'd1: ch = 8'h4E; // N
                    3'd2: ch = 8'h46; // F
                    3'd3: ch = 8'h4F; // O
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== design/vcf_header_line_tokenizer_top.sv =====
`default_nettype none

// Channel   | Direction | tdata (low bit up)                     | tuser | tlast
// ----------+-----------+----------------------------------------+-------+---------
// s_axis    | in        | char_in[7:0]                           | -     | line_end
// m_axis    | out       | char_out, pair_number, line_type,      | role  | last_out
//           |           | indexable, status, 2 zero bits         |       |
//
// One word in, one word out, one word per cycle sustained while m_axis is
// ready. Each word passes an input register, then the parser's next-state
// and tag logic feeding the result register. The parser state advances
// only when the input word moves into the result register. Reset
// (synchronous, active low) empties both registers and puts the parser at
// the start of a line. A stall on m_axis holds the result register and
// then the input register; s_axis stays ready while either has room.

module vcf_header_line_tokenizer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] char_out, [15:8] pair_number,
                                             // [17:16] line_type, [18] indexable,
                                             // [21:19] status, [23:22] zero
    output logic [2:0]       m_axis_tuser,   // [2:0] role
    output logic             m_axis_tlast    // last_out
);
    import vhlt_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    logic              out_can_load;
    logic              advance;
    t_result           parse_res;
    t_result           out_res;

    // Move the held input word into the result register when it has room
    assign advance       = r_in_valid && out_can_load;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Capture payload on every accepted word; hold it otherwise
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    vhlt_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_char    (r_in_char),
        .i_last    (r_in_last),
        .o_result  (parse_res)
    );

    vhlt_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_in_valid),
        .i_result   (parse_res),
        .i_ready    (m_axis_tready),
        .o_can_load (out_can_load),
        .o_valid    (m_axis_tvalid),
        .o_result   (out_res)
    );

    // Pack the result word
    assign m_axis_tdata = {2'b00, out_res.status, out_res.indexable, out_res.line_type,
                           out_res.pair_number, out_res.char_out};
    assign m_axis_tuser = out_res.role;
    assign m_axis_tlast = out_res.last_out;

endmodule

`default_nettype wire

// ===== design/vhlt_parser.sv =====
`default_nettype none

module vhlt_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_advance,
    input  wire logic [vhlt_pkg::CHAR_W-1:0]   i_char,
    input  wire logic                          i_last,
    output vhlt_pkg::t_result                  o_result
);
    import vhlt_pkg::*;

    typedef enum logic [3:0] {
        M_HASH1, M_HASH2, M_HKEY, M_AFTER_EQ, M_PLAIN, M_PSTART,
        M_PKEY, M_VSTART, M_VALUE, M_AFTER_Q, M_CLOSED, M_SINK
    } t_mode;

    t_mode               r_mode,  n_mode;
    logic [NCAND-1:0]    r_flags, n_flags;
    logic [KLEN_W-1:0]   r_klen,  n_klen;
    logic                r_quote, n_quote;
    logic [PAIR_W-1:0]   r_pair,  n_pair;
    logic [STATUS_W-1:0] r_err,   n_err;
    logic [TYPE_W-1:0]   r_type,  n_type;

    logic [CHAR_W-1:0]   upper;
    logic [PAIR_W-1:0]   pair_inc;
    logic [ROLE_W-1:0]   role;
    logic [PAIR_W-1:0]   pnum;
    logic [STATUS_W-1:0] status;

    assign upper    = (i_char >= CH_LC_A && i_char <= CH_LC_Z) ? (i_char - CH_CASE) : i_char;
    assign pair_inc = (r_pair == {PAIR_W{1'b1}}) ? r_pair : r_pair + PAIR_W'(1);

    always_comb begin
        n_mode  = r_mode;
        n_flags = r_flags;
        n_klen  = r_klen;
        n_quote = r_quote;
        n_pair  = r_pair;
        n_err   = r_err;
        n_type  = r_type;
        role    = ROLE_PLAIN;
        pnum    = '0;

        case (r_mode)
            M_HASH1, M_HASH2: begin
                role = ROLE_PREFIX;
                if (i_char == CH_HASH) begin
                    n_mode = (r_mode == M_HASH1) ? M_HASH2 : M_HKEY;
                end else begin
                    n_err  = ST_BAD_PREFIX;
                    n_mode = M_SINK;
                end
            end
            M_HKEY: begin
                if (i_char == CH_EQ) begin
                    role = ROLE_DELIM;
                    for (int i = 0; i < NCAND; i++) begin
                        if (r_klen != CAND_LEN[i]) n_flags[i] = 1'b0;
                    end
                    n_mode = M_AFTER_EQ;
                end else begin
                    role = ROLE_HKEY;
                    for (int i = 0; i < NCAND; i++) begin
                        if (r_klen >= CAND_LEN[i] || upper != cand_char(2'(i), r_klen))
                            n_flags[i] = 1'b0;
                    end
                    if (r_klen != {KLEN_W{1'b1}}) n_klen = r_klen + KLEN_W'(1);
                end
            end
            M_AFTER_EQ: begin
                if (i_char == CH_LT) begin
                    role = ROLE_DELIM;
                    if (r_flags[0])      n_type = TYPE_FORMAT;
                    else if (r_flags[1]) n_type = TYPE_FILTER;
                    else if (r_flags[2]) n_type = TYPE_INFO;
                    n_mode = M_PSTART;
                end else begin
                    role   = ROLE_PLAIN;
                    n_mode = M_PLAIN;
                end
            end
            M_PLAIN, M_SINK: begin
                role = ROLE_PLAIN;
            end
            M_PSTART: begin
                pnum = r_pair;
                if (i_char == CH_GT) begin
                    role = ROLE_CLOSE;  n_mode = M_CLOSED;
                end else if (i_char == CH_COMMA) begin
                    role = ROLE_DELIM;
                end else if (i_char == CH_EQ) begin
                    role = ROLE_DELIM;  n_mode = M_VSTART;
                end else begin
                    role = ROLE_PKEY;   n_mode = M_PKEY;
                end
            end
            M_PKEY: begin
                pnum = r_pair;
                if (i_char == CH_EQ) begin
                    role = ROLE_DELIM;  n_mode = M_VSTART;
                end else begin
                    role = ROLE_PKEY;
                end
            end
            M_VSTART, M_VALUE: begin
                pnum = r_pair;
                if (r_quote) begin
                    role = ROLE_PVAL;
                    if (i_char == CH_QUOTE) begin
                        n_quote = 1'b0;  n_mode = M_AFTER_Q;
                    end else if (i_char == CH_GT && i_last) begin
                        role = ROLE_CLOSE;  n_quote = 1'b0;  n_mode = M_CLOSED;
                    end
                end else if (i_char == CH_COMMA) begin
                    role = ROLE_DELIM;  n_pair = pair_inc;  n_mode = M_PSTART;
                end else if (i_char == CH_GT) begin
                    role = ROLE_CLOSE;  n_mode = M_CLOSED;
                end else begin
                    role = ROLE_PVAL;
                    if (r_mode == M_VSTART && i_char == CH_QUOTE) n_quote = 1'b1;
                    n_mode = M_VALUE;
                end
            end
            M_AFTER_Q: begin
                if (i_char == CH_COMMA) begin
                    pnum = r_pair;  role = ROLE_DELIM;
                    n_pair = pair_inc;  n_mode = M_PSTART;
                end else if (i_char == CH_GT) begin
                    pnum = r_pair;  role = ROLE_CLOSE;  n_mode = M_CLOSED;
                end else begin
                    n_pair = pair_inc;
                    pnum   = pair_inc;
                    if (i_char == CH_EQ) begin
                        role = ROLE_DELIM;  n_mode = M_VSTART;
                    end else begin
                        role = ROLE_PKEY;   n_mode = M_PKEY;
                    end
                end
            end
            M_CLOSED: begin
                // byte after the closing bracket
                role   = ROLE_PLAIN;
                n_err  = ST_NO_CLOSE;
                n_mode = M_SINK;
            end
            default: begin
                role   = ROLE_PLAIN;
                n_mode = M_SINK;
            end
        endcase

        // Line status from the state the last byte leaves behind
        status = ST_OK;
        if (i_last) begin
            if (n_err != ST_OK)                                       status = n_err;
            else if (n_mode == M_HASH1 || n_mode == M_HASH2)          status = ST_BAD_PREFIX;
            else if (n_mode == M_HKEY)                                status = ST_NO_EQUALS;
            else if (n_mode == M_AFTER_EQ || n_mode == M_PLAIN ||
                     n_mode == M_CLOSED)                              status = ST_OK;
            else if (n_mode == M_PKEY && i_char == CH_GT)             status = ST_OPEN_PKEY;
            else                                                      status = ST_NO_CLOSE;
        end
    end

    always_comb begin
        o_result.char_out    = i_char;
        o_result.role        = role;
        o_result.pair_number = pnum;
        o_result.line_type   = i_last ? n_type : TYPE_UNKNOWN;
        o_result.indexable   = i_last && (n_type != TYPE_UNKNOWN);
        o_result.status      = status;
        o_result.last_out    = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last)) begin
            r_mode  <= M_HASH1;
            r_flags <= {NCAND{1'b1}};
            r_klen  <= '0;
            r_quote <= 1'b0;
            r_pair  <= '0;
            r_err   <= ST_OK;
            r_type  <= TYPE_UNKNOWN;
        end else if (i_advance) begin
            r_mode  <= n_mode;
            r_flags <= n_flags;
            r_klen  <= n_klen;
            r_quote <= n_quote;
            r_pair  <= n_pair;
            r_err   <= n_err;
            r_type  <= n_type;
        end
    end

endmodule

`default_nettype wire

// ===== design/vhlt_out_reg.sv =====
`default_nettype none

module vhlt_out_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire vhlt_pkg::t_result i_result,
    input  wire logic       i_ready,
    output logic            o_can_load,
    output logic            o_valid,
    output vhlt_pkg::t_result o_result
);
    import vhlt_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Take a new word when empty or when the held word leaves this cycle
    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== test/vhlt_tag_checker.sv =====
`timescale 1ns / 100ps

module vhlt_tag_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [23:0] i_out_data,
    input  wire logic [2:0]  i_out_role,
    input  wire logic        i_out_last,
    output int               o_fail_count,
    output int               o_pending
);
    import vhlt_pkg::*;

    typedef enum logic [3:0] {
        P_HASH1, P_HASH2, P_HKEY, P_AFTER_EQ, P_PLAIN, P_PSTART,
        P_PKEY, P_VSTART, P_VALUE, P_AFTER_Q, P_CLOSED, P_SINK
    } t_parse;

    localparam logic [7:0] KEY_TEXT [NCAND][6] = '{
        '{"F", "O", "R", "M", "A", "T"},
        '{"F", "I", "L", "T", "E", "R"},
        '{"I", "N", "F", "O", 8'h00, 8'h00}
    };

    t_parse              mode;
    logic [NCAND-1:0]    match_flags;
    logic [KLEN_W-1:0]   key_len;
    logic                quoted;
    logic [PAIR_W-1:0]   pair_idx;
    logic [STATUS_W-1:0] err_code;
    logic [TYPE_W-1:0]   kind;

    t_result expected_tags[$];
    int      fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic void clear_line();
        mode        = P_HASH1;
        match_flags = '1;
        key_len     = '0;
        quoted      = 1'b0;
        pair_idx    = '0;
        err_code    = ST_OK;
        kind        = TYPE_UNKNOWN;
    endfunction

    function automatic void advance_pair();
        if (pair_idx != '1) pair_idx++;
    endfunction

    // Tag one byte and advance the line parse
    function automatic t_result tag_byte(input logic [7:0] c, input logic last);
        t_result             r;
        logic [7:0]          up;
        logic [ROLE_W-1:0]   role;
        logic [PAIR_W-1:0]   pnum;
        logic [STATUS_W-1:0] st;
        role = ROLE_PLAIN;
        pnum = '0;
        st   = ST_OK;
        case (mode)
            P_HASH1, P_HASH2: begin
                role = ROLE_PREFIX;
                if (c == CH_HASH) begin
                    mode = (mode == P_HASH1) ? P_HASH2 : P_HKEY;
                end else begin
                    err_code = ST_BAD_PREFIX;
                    mode     = P_SINK;
                end
            end
            P_HKEY: begin
                if (c == CH_EQ) begin
                    role = ROLE_DELIM;
                    for (int i = 0; i < NCAND; i++)
                        if (key_len != CAND_LEN[i]) match_flags[i] = 1'b0;
                    mode = P_AFTER_EQ;
                end else begin
                    role = ROLE_HKEY;
                    up   = (c >= CH_LC_A && c <= CH_LC_Z) ? c - CH_CASE : c;
                    for (int i = 0; i < NCAND; i++) begin
                        if (key_len >= CAND_LEN[i]) match_flags[i] = 1'b0;
                        else if (up != KEY_TEXT[i][key_len]) match_flags[i] = 1'b0;
                    end
                    if (key_len != '1) key_len++;
                end
            end
            P_AFTER_EQ: begin
                if (c == CH_LT) begin
                    role = ROLE_DELIM;
                    if (match_flags[0]) kind = TYPE_FORMAT;
                    else if (match_flags[1]) kind = TYPE_FILTER;
                    else if (match_flags[2]) kind = TYPE_INFO;
                    mode = P_PSTART;
                end else begin
                    role = ROLE_PLAIN;
                    mode = P_PLAIN;
                end
            end
            P_PLAIN, P_SINK: role = ROLE_PLAIN;
            P_PSTART: begin
                pnum = pair_idx;
                if (c == CH_GT) begin
                    role = ROLE_CLOSE;
                    mode = P_CLOSED;
                end else if (c == CH_COMMA) begin
                    role = ROLE_DELIM;
                end else if (c == CH_EQ) begin
                    role = ROLE_DELIM;
                    mode = P_VSTART;
                end else begin
                    role = ROLE_PKEY;
                    mode = P_PKEY;
                end
            end
            P_PKEY: begin
                pnum = pair_idx;
                if (c == CH_EQ) begin
                    role = ROLE_DELIM;
                    mode = P_VSTART;
                end else begin
                    role = ROLE_PKEY;
                end
            end
            P_VSTART, P_VALUE: begin
                pnum = pair_idx;
                if (quoted) begin
                    role = ROLE_PVAL;
                    if (c == CH_QUOTE) begin
                        quoted = 1'b0;
                        mode   = P_AFTER_Q;
                    end else if (c == CH_GT && last) begin
                        role   = ROLE_CLOSE;
                        quoted = 1'b0;
                        mode   = P_CLOSED;
                    end
                end else if (c == CH_COMMA) begin
                    role = ROLE_DELIM;
                    advance_pair();
                    mode = P_PSTART;
                end else if (c == CH_GT) begin
                    role = ROLE_CLOSE;
                    mode = P_CLOSED;
                end else begin
                    role = ROLE_PVAL;
                    if (mode == P_VSTART && c == CH_QUOTE) quoted = 1'b1;
                    mode = P_VALUE;
                end
            end
            P_AFTER_Q: begin
                if (c == CH_COMMA) begin
                    pnum = pair_idx;
                    role = ROLE_DELIM;
                    advance_pair();
                    mode = P_PSTART;
                end else if (c == CH_GT) begin
                    pnum = pair_idx;
                    role = ROLE_CLOSE;
                    mode = P_CLOSED;
                end else begin
                    // Anything else opens the next pair right away
                    advance_pair();
                    pnum = pair_idx;
                    if (c == CH_EQ) begin
                        role = ROLE_DELIM;
                        mode = P_VSTART;
                    end else begin
                        role = ROLE_PKEY;
                        mode = P_PKEY;
                    end
                end
            end
            default: begin
                // Byte after the closing bracket
                role     = ROLE_PLAIN;
                err_code = ST_NO_CLOSE;
                mode     = P_SINK;
            end
        endcase

        if (last) begin
            if (err_code != ST_OK) st = err_code;
            else begin
                case (mode)
                    P_HASH1, P_HASH2:              st = ST_BAD_PREFIX;
                    P_HKEY:                        st = ST_NO_EQUALS;
                    P_AFTER_EQ, P_PLAIN, P_CLOSED: st = ST_OK;
                    P_PKEY:  st = (c == CH_GT) ? ST_OPEN_PKEY : ST_NO_CLOSE;
                    default: st = ST_NO_CLOSE;
                endcase
            end
        end

        r.char_out    = c;
        r.role        = role;
        r.pair_number = pnum;
        r.line_type   = last ? kind : TYPE_UNKNOWN;
        r.indexable   = last && (kind != TYPE_UNKNOWN);
        r.status      = st;
        r.last_out    = last;
        if (last) clear_line();
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_line();
            expected_tags.delete();
        end else begin
            // Compare the outgoing word before queueing the incoming one
            if (i_out_valid && i_out_ready) begin
                if (expected_tags.size() == 0) begin
                    $error("unexpected result word: char_out %0h", i_out_data[7:0]);
                    fail_total++;
                end else begin
                    want = expected_tags.pop_front();
                    check_field("char_out", want.char_out, i_out_data[7:0]);
                    check_field("role", want.role, i_out_role);
                    check_field("pair_number", want.pair_number, i_out_data[15:8]);
                    check_field("line_type", want.line_type, i_out_data[17:16]);
                    check_field("indexable", want.indexable, i_out_data[18]);
                    check_field("status", want.status, i_out_data[21:19]);
                    check_field("last_out", want.last_out, i_out_last);
                    check_field("tdata padding", 32'd0, i_out_data[23:22]);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_tags = {expected_tags, tag_byte(i_in_byte, i_in_last)};
        end
        o_pending = expected_tags.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import vhlt_pkg::*;

    // Stop the random part once this many words have gone in
    localparam int ITEM_TARGET  = 1050;
    // Far above the slowest legal run: ~1100 words, each at worst a full
    // sender gap plus a long receiver stall
    localparam int CYCLE_LIMIT  = 300000;
    // Two-stage pipeline; let extra cycles pass at the end
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_in
    logic        s_axis_tlast;   // line_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [7:0] char_out, [15:8] pair_number, [17:16] line_type,
                                 // [18] indexable, [21:19] status, [23:22] zero
    logic [2:0]  m_axis_tuser;   // [2:0] role
    logic        m_axis_tlast;   // last_out

    int fail_count;
    int pending_words;
    int sent_words  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    // Bytes of the line being built, sent in order with tlast on the final one
    logic [7:0] line_buf[$];

    vcf_header_line_tokenizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    vhlt_tag_checker u_tag_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_role   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the pipeline hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("vcf_header_line_tokenizer_top test failed");
            $finish;
        end
    end

    // Receiver: switch at random between stall patterns
    // (always ready, coin flip, mostly stalled, regular quarter-duty ready)
    initial begin
        int pattern;
        int pattern_left;
        int phase;
        pattern       = 0;
        pattern_left  = 0;
        phase         = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pattern_left == 0) begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(16, 200);
            end
            pattern_left--;
            phase++;
            case (pattern)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (phase % 4 == 0);
            endcase
        end
    end

    // Send one word: insert an idle gap between bursts, then hold valid
    // until the handshake completes at a rising edge
    task automatic send_word(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        // tready is settled shortly after the falling edge
        #1;
        while (!s_axis_tready) begin
            @(negedge i_clk);
            #1;
        end
        @(posedge i_clk);
        sent_words++;
    endtask

    task automatic send_line();
        for (int k = 0; k < line_buf.size(); k++)
            send_word(line_buf[k], k == line_buf.size() - 1);
        line_buf.delete();
    endtask

    // Drop valid and hold off until every expected word has come back
    task automatic pause_until_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_words != 0) @(negedge i_clk);
    endtask

    // Append one byte to the line being built
    function automatic void add_byte(input logic [7:0] b);
        line_buf = {line_buf, b};
    endfunction

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
    endtask

    function automatic logic [7:0] name_byte();
        string alnum;
        alnum = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_.";
        return alnum[$urandom_range(0, alnum.len() - 1)];
    endfunction

    // Any byte that does not end an unquoted value
    function automatic logic [7:0] value_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_COMMA || b == CH_GT) b = "v";
        return b;
    endfunction

    // Any byte but the closing quote; '>' and ',' stay inside the value
    function automatic logic [7:0] quoted_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_QUOTE) b = CH_GT;
        return b;
    endfunction

    // Header key: the known types in mixed case, other keys, random bytes, plus near misses
    // (prefixes, longer keys, keys past the length counter's range)
    task automatic push_header_key();
        string      keys[14];
        string      pick;
        logic [7:0] ch;
        keys = '{"FORMAT", "FILTER", "INFO", "format", "filter", "info", "FORM",
                 "INF", "INFOS", "FILTERED", "INFORMATION", "ALT", "contig", ""};
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 9)) add_byte(value_byte());
        end else begin
            pick = keys[$urandom_range(0, 13)];
            for (int k = 0; k < pick.len(); k++) begin
                ch = pick[k];
                // Flip case on some letters to exercise the folding
                if ((ch | CH_CASE) >= CH_LC_A && (ch | CH_CASE) <= CH_LC_Z
                        && $urandom_range(0, 2) == 0)
                    ch = ch ^ CH_CASE;
                add_byte(ch);
            end
        end
    endtask

    initial begin
        int  kind;
        int  npairs;
        int  cut;
        bit  quoted;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: bad first byte at the low extreme, bad second
        // byte at the high extreme, line cut inside the prefix, line ending
        // on '=', line ending inside the header key, empty INFO body
        add_byte(8'h00);
        send_line();
        push_text("#");
        add_byte(8'hFF);
        send_line();
        push_text("#");
        send_line();
        push_text("##=");
        send_line();
        push_text("##X");
        send_line();
        push_text("##INFO=<>");
        send_line();
        pause_until_drained();

        // Long line of empty keyed pairs drives the pair number to saturation
        push_text("##FILTER=<");
        repeat (265) push_text("=,");
        push_text("ID=x>");
        send_line();
        pause_until_drained();

        while (sent_words < ITEM_TARGET) begin
            kind = $urandom_range(0, 19);
            if (kind <= 11 || kind >= 17) begin
                // Structured body with random pairs
                push_text("##");
                push_header_key();
                push_text("=<");
                npairs = $urandom_range(0, 5);
                for (int p = 0; p < npairs; p++) begin
                    if ($urandom_range(0, 7) == 0) push_text(",");
                    repeat ($urandom_range(0, 4)) add_byte(name_byte());
                    // Leave the last key open so '>' lands inside it
                    if (p == npairs - 1 && $urandom_range(0, 5) == 0) break;
                    push_text("=");
                    quoted = ($urandom_range(0, 3) == 0);
                    if (quoted) begin
                        push_text("\"");
                        repeat ($urandom_range(0, 4)) add_byte(quoted_byte());
                        push_text("\"");
                    end else begin
                        repeat ($urandom_range(0, 4)) add_byte(value_byte());
                    end
                    // After a closing quote, sometimes run straight into the next key
                    if (p != npairs - 1 && !(quoted && $urandom_range(0, 2) == 0))
                        push_text(",");
                end
                push_text(">");
                case ($urandom_range(0, 7))
                    0: begin
                        // Cut the line short anywhere
                        cut = $urandom_range(1, line_buf.size());
                        while (line_buf.size() > cut) void'(line_buf.pop_back());
                    end
                    1: repeat ($urandom_range(1, 3)) add_byte(value_byte());
                    default: ;
                endcase
            end else if (kind <= 13) begin
                // Plain value after '='
                push_text("##");
                push_header_key();
                push_text("=");
                repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
            end else if (kind == 14) begin
                // Quote never closed, line ends on '>'
                push_text("##");
                push_header_key();
                push_text("=<");
                repeat ($urandom_range(1, 3)) add_byte(name_byte());
                push_text("=\"");
                repeat ($urandom_range(0, 4)) add_byte(quoted_byte());
                push_text(">");
            end else if (kind == 15) begin
                // Noise, sometimes with a valid first hash
                if ($urandom_range(0, 1) == 0) push_text("#");
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
            end else begin
                // Header key with no '='
                push_text("##");
                push_header_key();
            end
            send_line();
            if ($urandom_range(0, 39) == 0) pause_until_drained();
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("vcf_header_line_tokenizer_top test passed");
        end else begin
            $display("vcf_header_line_tokenizer_top test failed");
        end
        $finish;
    end

endmodule

// ===== vcf_header_line_tokenizer_top.f =====
design/vhlt_pkg.sv
design/vhlt_parser.sv
design/vhlt_out_reg.sv
design/vcf_header_line_tokenizer_top.sv
test/vhlt_tag_checker.sv
test/testbench.sv
